>>> hw/rtl/hcfq_pkg.sv
// Shared types, constants and codes for the HCI command flow queue.
package hcfq_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int TIME_W     = 56;
  localparam int TMO_W      = 32;
  localparam int OPC_W      = 16;
  localparam int CRED_W     = 8;
  localparam int STAT_W     = 8;
  localparam int SLOT_OUT_W = 6;

  localparam logic [TMO_W-1:0]  DEFAULT_TIMEOUT_RST = 32'd5000000;
  localparam logic [STAT_W-1:0] STATUS_NONE         = 8'hFF;
  localparam logic [TIME_W-1:0] TIME_MAX            = {TIME_W{1'b1}};
  localparam logic [CRED_W-1:0] CREDIT_RST          = 8'd1;

  localparam logic CAUSE_ANSWERED = 1'b0;
  localparam logic CAUSE_TIMEOUT  = 1'b1;

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_STATUS   = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REFUSED  = 2'd1,
    KIND_SEND     = 2'd2,
    KIND_FINISHED = 2'd3
  } kind_t;

  typedef struct packed {
    op_t               operation;
    logic [OPC_W-1:0]  opcode;
    logic [TMO_W-1:0]  timeout;
    logic [CRED_W-1:0] credits_granted;
    logic [STAT_W-1:0] event_status;
    logic              status_present;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    kind_t                 kind;
    logic [SLOT_OUT_W-1:0] slot;
    logic [OPC_W-1:0]      opcode_res;
    logic                  finish_cause;
    logic [STAT_W-1:0]     status;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic pump;
  } ctrl_t;

  typedef struct packed {
    logic is_submit;
    logic pump_ok;
  } stat_t;

endpackage

>>> hw/rtl/hci_command_flow_queue_top.sv
// Top level of the HCI command flow queue.
//
//   channel  ports                         beat taken when
//   input    start, busy, in_item          start && !busy
//   result   out_valid, out_item           out_valid (one cycle)
//   config   cfg_we, cfg_wdata             cfg_we
//
// A submit: load, evaluate. An event or tick adds a send step if it sends a command.
// Results appear in the cycle after the evaluate or send step, from the result register.
// Reset is synchronous, active low; credits start at one, the queue empty.
// The receiver cannot stall; each result beat is valid for exactly one cycle.
module hci_command_flow_queue_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hcfq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output hcfq_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata
);
  import hcfq_pkg::*;

  ctrl_t cmd;
  stat_t stat;

  hcfq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  hcfq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> hw/rtl/hcfq_datapath.sv
// Slot store, order queue, credit and deadline logic, result register.
module hcfq_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  hcfq_pkg::ctrl_t     cmd,
  output hcfq_pkg::stat_t     stat,
  input  hcfq_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  output logic                out_valid,
  output hcfq_pkg::out_item_t out_item
);
  import hcfq_pkg::*;

  in_item_t          item_r;
  logic [TMO_W-1:0]  dflt_tmo_r;
  logic [SLOT_COUNT-1:0] slot_busy_r;
  logic [OPC_W-1:0]  slot_opcode_r [SLOT_COUNT];
  logic [TMO_W-1:0]  slot_tmo_r    [SLOT_COUNT];
  logic [SLOT_W-1:0] order_r       [SLOT_COUNT];
  logic [SLOT_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0]  count_r;
  logic              bvalid_r;
  logic [SLOT_W-1:0] bslot_r;
  logic [OPC_W-1:0]  bopcode_r;
  logic [CRED_W-1:0] credit_r;
  logic [TIME_W-1:0] latest_r;
  logic [TIME_W-1:0] deadline_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              out_valid_nxt;
  out_item_t         out_item_nxt;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              is_submit, is_tick, do_finish, pump_ok;
  logic [CRED_W-1:0] credit_new;
  logic [TMO_W-1:0]  tmo_sel;
  logic [SLOT_W-1:0] head_slot, head_nxt, tail_nxt;
  logic [TIME_W:0]   dl_sum;
  logic [TIME_W-1:0] deadline_nxt;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    is_submit = (item_r.operation == OP_SUBMIT);
    is_tick   = (item_r.operation == OP_TICK);
    if (is_tick) begin
      do_finish = bvalid_r && (latest_r >= deadline_r);
    end else begin
      do_finish = !is_submit && bvalid_r && (bopcode_r == item_r.opcode);
    end
    if (is_tick) begin
      credit_new = do_finish ? CREDIT_RST : credit_r;
    end else begin
      credit_new = item_r.credits_granted;
    end
    pump_ok = !(bvalid_r && !do_finish) && (credit_new != '0) && (count_r != '0);
    if (item_r.timeout != '0) begin
      tmo_sel = item_r.timeout;
    end else if (dflt_tmo_r == '0) begin
      tmo_sel = TMO_W'(1);
    end else begin
      tmo_sel = dflt_tmo_r;
    end
    head_slot    = order_r[head_r];
    head_nxt     = (head_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : head_r + SLOT_W'(1);
    tail_nxt     = (tail_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : tail_r + SLOT_W'(1);
    dl_sum       = {1'b0, latest_r} + {{(TIME_W + 1 - TMO_W){1'b0}}, slot_tmo_r[head_slot]};
    deadline_nxt = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
  end

  assign stat.is_submit = is_submit;
  assign stat.pump_ok   = pump_ok;

  always_comb begin
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    if (cmd.eval) begin
      if (is_submit) begin
        out_valid_nxt           = 1'b1;
        out_item_nxt.kind       = free_found ? KIND_ACCEPTED : KIND_REFUSED;
        out_item_nxt.slot       = free_found ? SLOT_OUT_W'(free_idx) : '0;
        out_item_nxt.opcode_res = item_r.opcode;
        out_item_nxt.last       = 1'b1;
      end else if (do_finish) begin
        out_valid_nxt             = 1'b1;
        out_item_nxt.kind         = KIND_FINISHED;
        out_item_nxt.slot         = SLOT_OUT_W'(bslot_r);
        out_item_nxt.opcode_res   = bopcode_r;
        out_item_nxt.finish_cause = is_tick ? CAUSE_TIMEOUT : CAUSE_ANSWERED;
        if (is_tick) begin
          out_item_nxt.status = STATUS_NONE;
        end else if (item_r.operation == OP_STATUS || item_r.status_present) begin
          out_item_nxt.status = item_r.event_status;
        end else begin
          out_item_nxt.status = STATUS_NONE;
        end
        out_item_nxt.last = !pump_ok;
      end
    end else if (cmd.pump) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.kind       = KIND_SEND;
      out_item_nxt.slot       = SLOT_OUT_W'(head_slot);
      out_item_nxt.opcode_res = slot_opcode_r[head_slot];
      out_item_nxt.last       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_tmo_r  <= DEFAULT_TIMEOUT_RST;
      slot_busy_r <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      bvalid_r    <= 1'b0;
      bslot_r     <= '0;
      credit_r    <= CREDIT_RST;
      latest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        dflt_tmo_r <= cfg_wdata;
      end
      if (cmd.load && in_item.operation != OP_SUBMIT && in_item.now_time > latest_r) begin
        latest_r <= in_item.now_time;
      end
      if (cmd.eval) begin
        if (is_submit) begin
          if (free_found) begin
            slot_busy_r[free_idx] <= 1'b1;
            tail_r                <= tail_nxt;
            count_r               <= count_r + CNT_W'(1);
          end
        end else begin
          credit_r <= credit_new;
          if (do_finish) begin
            bvalid_r              <= 1'b0;
            slot_busy_r[bslot_r]  <= 1'b0;
          end
        end
      end
      if (cmd.pump) begin
        head_r   <= head_nxt;
        count_r  <= count_r - CNT_W'(1);
        credit_r <= credit_r - CRED_W'(1);
        bvalid_r <= 1'b1;
        bslot_r  <= head_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.eval && is_submit && free_found) begin
      slot_opcode_r[free_idx] <= item_r.opcode;
      slot_tmo_r[free_idx]    <= tmo_sel;
      order_r[tail_r]         <= free_idx;
    end
    if (cmd.pump) begin
      bopcode_r  <= slot_opcode_r[head_slot];
      deadline_r <= deadline_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_slot_account: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_busy_r) == int'(count_r) + int'(bvalid_r))
    else $error("busy slots differ from queued plus outstanding");

  a_pump_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pump |-> (!bvalid_r && credit_r != '0 && count_r != '0))
    else $error("send issued without credit, queue entry or free line");

  a_pump_credit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pump |=> (credit_r == $past(credit_r) - CRED_W'(1)) && bvalid_r)
    else $error("send did not spend one credit");

  a_busy_slot: assert property (@(posedge clk) disable iff (!rst_n)
    bvalid_r |-> slot_busy_r[bslot_r])
    else $error("outstanding command on a free slot");

endmodule

>>> hw/rtl/hcfq_ctrl.sv
// Sequencer for the HCI command flow queue: load, evaluate, send.
module hcfq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  hcfq_pkg::stat_t stat,
  output hcfq_pkg::ctrl_t cmd
);
  import hcfq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_PUMP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (!stat.is_submit && stat.pump_ok) state_nxt = ST_PUMP;
        else state_nxt = ST_IDLE;
      end
      ST_PUMP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign cmd.load = start && (state_r == ST_IDLE);
  assign cmd.eval = (state_r == ST_EVAL);
  assign cmd.pump = (state_r == ST_PUMP);

endmodule
